>>> sv/mccp_pkg.sv
// Shared constants and types for the MIDI program/control change parser.
package mccp_pkg;

  // Time stamp arithmetic width (capped at 32 bits); the time port carries 32 bits.
  localparam int TIME_BITS = 32;
  localparam int TIME_W    = (TIME_BITS < 32) ? TIME_BITS : 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_EN = 2'd2;

  // Event kinds
  localparam logic KIND_PROGRAM = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  // Status nibbles and controller numbers
  localparam logic [3:0] STATUS_CC   = 4'hB;
  localparam logic [3:0] STATUS_PC   = 4'hC;
  localparam logic [7:0] CC_BANK_MSB = 8'd0;
  localparam logic [7:0] CC_BANK_LSB = 8'd32;
  localparam logic [7:0] CC_FIRST    = 8'd70;
  localparam logic [7:0] CC_LAST     = 8'd83;

  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic        program_event_enable;
    logic        control_event_enable;
  } mccp_cfg_t;

  typedef struct packed {
    logic        event_kind;
    logic [3:0]  channel;
    logic [7:0]  program_number;
    logic [15:0] bank_number;
    logic [7:0]  controller_number;
    logic [7:0]  controller_value;
  } mccp_event_t;

endpackage

>>> sv/midi_cc_program_change_parser_unit.sv
// Top level of the MIDI program change / control change parser.
//
// Input channel (in_valid / in_stall): one MIDI byte per beat with its time
// stamp. Output channel (out_valid / out_stall): one event beat carrying the
// full held record (channel, program, bank, controller, value) plus its kind.
// Config channel (cfg_valid / cfg_ready): index 0 timeout, 1 program event
// enable, 2 control event enable; always ready, write only while idle.
//
// Throughput: one byte per cycle while in_stall is low. Parser state updates
// at the accept edge; an event is registered into the output register, or
// the skid entry if stalled. Bytes completing no enabled message give no beat.
//
// Stall: an output register plus one skid entry sit behind the parser, so a
// byte is still taken while an event waits. in_stall rises only when both
// entries hold events and drops the cycle after the receiver takes one.
//
// Reset (rst, synchronous): parser goes idle, held record, last time stamp
// and all config registers clear to zero, both output entries empty.
module midi_cc_program_change_parser_unit (
  input  logic                           clk,
  input  logic                           rst,
  // config write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mccp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  input  logic [31:0]                    time_now,
  // event output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           event_kind,
  output logic [3:0]                     channel,
  output logic [7:0]                     program_number,
  output logic [15:0]                    bank_number,
  output logic [7:0]                     controller_number,
  output logic [7:0]                     controller_value
);
  import mccp_pkg::*;

  mccp_cfg_t   cfg;
  mccp_event_t ev;
  mccp_event_t out_ev;
  logic        ev_valid;
  logic        take;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT: cfg.timeout_ticks        <= cfg_data;
        CFG_PROG_EN: cfg.program_event_enable <= cfg_data[0];
        CFG_CTRL_EN: cfg.control_event_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mccp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .time_now (time_now),
    .cfg      (cfg),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  mccp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_valid),
    .push_ev   (ev),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign event_kind        = out_ev.event_kind;
  assign channel           = out_ev.channel;
  assign program_number    = out_ev.program_number;
  assign bank_number       = out_ev.bank_number;
  assign controller_number = out_ev.controller_number;
  assign controller_value  = out_ev.controller_value;

  // skid entry is only ever occupied behind a valid output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry holds an event while output register is empty");

  // skid fills only when an event arrives while the output is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall && ev_valid))
    else $error("skid entry filled without a stalled output");

  // a new event beat always stems from an enabled message kind
  a_kind_enabled: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> ((ev.event_kind == KIND_PROGRAM && cfg.program_event_enable) ||
                  (ev.event_kind == KIND_CONTROL && cfg.control_event_enable)))
    else $error("event produced for a disabled message kind");

endmodule

>>> sv/mccp_parser.sv
// Byte parser: phase state, held record, idle timeout and event decode.
module mccp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         time_now,
  input  mccp_pkg::mccp_cfg_t cfg,
  output logic                ev_valid,
  output mccp_pkg::mccp_event_t ev
);
  import mccp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PROGRAM = 3'd1,
    PH_CONTROL = 3'd2,
    PH_BANK_LO = 3'd3,
    PH_BANK_HI = 3'd4,
    PH_VALUE   = 3'd5
  } phase_t;

  phase_t      phase, phase_next, phase_cur;
  logic [3:0]  held_channel, held_channel_next;
  logic [7:0]  held_program, held_program_next;
  logic [15:0] held_bank, held_bank_next;
  logic [7:0]  held_controller, held_controller_next;
  logic [7:0]  held_value, held_value_next;
  logic [TIME_W-1:0] last_byte_time;
  logic [TIME_W-1:0] elapsed;
  logic        timed_out;
  logic        emit;
  logic        emit_kind;

  assign elapsed   = time_now[TIME_W-1:0] - last_byte_time;
  assign timed_out = 32'(elapsed) > cfg.timeout_ticks;
  assign phase_cur = timed_out ? PH_IDLE : phase;

  always_comb begin
    phase_next           = PH_IDLE;
    held_channel_next    = held_channel;
    held_program_next    = held_program;
    held_bank_next       = held_bank;
    held_controller_next = held_controller;
    held_value_next      = held_value;
    emit                 = 1'b0;
    emit_kind            = KIND_PROGRAM;
    case (phase_cur)
      PH_IDLE: begin
        if (rx_byte[7:4] == STATUS_CC) begin
          held_channel_next = rx_byte[3:0];
          phase_next        = PH_CONTROL;
        end else if (rx_byte[7:4] == STATUS_PC) begin
          held_channel_next = rx_byte[3:0];
          phase_next        = PH_PROGRAM;
        end
      end
      PH_PROGRAM: begin
        held_program_next = rx_byte;
        emit              = cfg.program_event_enable;
        emit_kind         = KIND_PROGRAM;
      end
      PH_CONTROL: begin
        if (rx_byte == CC_BANK_MSB) begin
          phase_next = PH_BANK_HI;
        end else if (rx_byte == CC_BANK_LSB) begin
          phase_next = PH_BANK_LO;
        end else if (rx_byte >= CC_FIRST && rx_byte <= CC_LAST) begin
          held_controller_next = rx_byte;
          phase_next           = PH_VALUE;
        end
      end
      PH_BANK_LO: held_bank_next = {held_bank[15:8], rx_byte};
      PH_BANK_HI: held_bank_next = {rx_byte, held_bank[7:0]};
      PH_VALUE: begin
        held_value_next = rx_byte;
        emit            = cfg.control_event_enable;
        emit_kind       = KIND_CONTROL;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign ev_valid             = take && emit;
  assign ev.event_kind        = emit_kind;
  assign ev.channel           = held_channel_next;
  assign ev.program_number    = held_program_next;
  assign ev.bank_number       = held_bank_next;
  assign ev.controller_number = held_controller_next;
  assign ev.controller_value  = held_value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      held_channel    <= '0;
      held_program    <= '0;
      held_bank       <= '0;
      held_controller <= '0;
      held_value      <= '0;
      last_byte_time  <= '0;
    end else if (take) begin
      phase           <= phase_next;
      held_channel    <= held_channel_next;
      held_program    <= held_program_next;
      held_bank       <= held_bank_next;
      held_controller <= held_controller_next;
      held_value      <= held_value_next;
      last_byte_time  <= time_now[TIME_W-1:0];
    end
  end

endmodule

>>> sv/mccp_out_buf.sv
// Output register with one skid entry for event beats.
module mccp_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mccp_pkg::mccp_event_t push_ev,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mccp_pkg::mccp_event_t out_ev
);
  import mccp_pkg::*;

  mccp_event_t skid_ev;
  logic        skid_valid;
  logic        pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is held off while the skid entry is occupied
      if (pop) begin
        out_ev     <= skid_ev;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_ev    <= push_ev;
        out_valid <= 1'b1;
      end else begin
        skid_ev    <= push_ev;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
